// File: sv/mde_pkg.sv
// Shared types, codes and helpers for the depth-first maze explorer.
package mde_pkg;

    localparam int GRID_BITS_DEF = 6;
    // Width of the visited-map tag; one tag value per run before a sweep
    localparam int TAG_W         = 4;

    localparam int KIND_W  = 2;
    localparam int DIR_W   = 3;
    localparam int STEPS_W = 12;
    localparam int COORD_W = 6;
    localparam int REPLY_W = 2;

    localparam logic                 FUNC_START  = 1'b0;

    localparam logic [REPLY_W-1:0]   REPLY_WALL  = 2'd0;
    localparam logic [REPLY_W-1:0]   REPLY_MOVED = 2'd1;
    localparam logic [REPLY_W-1:0]   REPLY_FOUND = 2'd2;

    localparam logic [KIND_W-1:0]    KIND_MOVE   = 2'd0;
    localparam logic [KIND_W-1:0]    KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0]    KIND_BOUND  = 2'd2;

    localparam logic [DIR_W-1:0]     MOVE_NONE   = 3'd0;

    // Direction index as kept in the stack: north, south, west, east
    typedef logic [1:0] dir_idx_t;
    localparam dir_idx_t IDX_NORTH = 2'd0;
    localparam dir_idx_t IDX_SOUTH = 2'd1;
    localparam dir_idx_t IDX_WEST  = 2'd2;
    localparam dir_idx_t IDX_EAST  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [DIR_W-1:0]          move_dir;
        logic                      found;
        logic [STEPS_W-1:0]        steps;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } result_t;

    function automatic dir_idx_t rev_dir(input dir_idx_t d);
        dir_idx_t r;
        unique case (d)
            IDX_NORTH: r = IDX_SOUTH;
            IDX_SOUTH: r = IDX_NORTH;
            IDX_WEST:  r = IDX_EAST;
            default:   r = IDX_WEST;
        endcase
        return r;
    endfunction

    // Command code on the bus is the index plus one
    function automatic logic [DIR_W-1:0] dir_code(input dir_idx_t d);
        return {1'b0, d} + DIR_W'(1);
    endfunction

endpackage

// File: sv/maze_dfs_explorer_core.sv
// Depth-first maze explorer: top level with visited map, direction stack and result register.
//
// Input stream (s_*): a beat with s_tuser = 0 starts a new run at (start_x, start_y);
// s_tuser = 1 carries the robot reply to the last move command. A reply with no run
// active is taken and dropped. Result stream (m_*): one beat per start or reply, except
// an ignored reply; m_tuser says move command, run finished, or grid bound error.
// Latency: the result sits in the output register the cycle after its input beat.
// Flow control: after each beat s_tready drops while the design reads the
// visited map (tag of the cell ahead) and the direction stack (entry under the top);
// both single-port memories are read then, and written in the accept cycle.
// The visited map holds a run tag, so a start does not wipe it. After reset, and on
// every (2^TAG_W - 1)-th start when the tag rolls over, a sweep over all 2^(2*GRID_BITS)
// cells (4096 at the default) clears the map; s_tready stays low meanwhile.
// Reset is synchronous (aresetn low): run state cleared, output register emptied.
// A stalled receiver holds the result; one new beat is still taken if m_tready
// frees the output register in the same cycle.
module maze_dfs_explorer_core
    import mde_pkg::*;
#(
    parameter int GRID_BITS = GRID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reply[1:0], start_x[7:2], start_y[13:8], zero pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // move_dir[2:0], found[3], steps[15:4], pos_x[21:16],
                                   // pos_y[27:22], zero pad
    output logic [1:0]  m_tuser    // kind
);

    localparam int CELL_W  = 2 * GRID_BITS;
    localparam int DEPTH_W = CELL_W;
    localparam int CELLS   = 1 << CELL_W;

    typedef logic signed [GRID_BITS-1:0] coord_t;
    localparam coord_t C_MIN = {1'b1, {(GRID_BITS-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(GRID_BITS-1){1'b1}}};
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = {TAG_W{1'b1}};

    typedef enum logic [1:0] {PH_IDLE, PH_PROBE, PH_UNDO, PH_BACK} phase_t;

    function automatic coord_t step_x(input coord_t x, input dir_idx_t d);
        coord_t r;
        unique case (d)
            IDX_WEST: r = x - coord_t'(1);
            IDX_EAST: r = x + coord_t'(1);
            default:  r = x;
        endcase
        return r;
    endfunction

    function automatic coord_t step_y(input coord_t y, input dir_idx_t d);
        coord_t r;
        unique case (d)
            IDX_NORTH: r = y + coord_t'(1);
            IDX_SOUTH: r = y - coord_t'(1);
            default:   r = y;
        endcase
        return r;
    endfunction

    function automatic logic leaves_grid(input coord_t x, input coord_t y, input dir_idx_t d);
        logic r;
        unique case (d)
            IDX_NORTH: r = (y == C_MAX);
            IDX_SOUTH: r = (y == C_MIN);
            IDX_WEST:  r = (x == C_MIN);
            default:   r = (x == C_MAX);
        endcase
        return r;
    endfunction

    // Registers
    phase_t              phase_reg, phase_next;
    coord_t              cur_x_reg, cur_x_next;
    coord_t              cur_y_reg, cur_y_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]  max_reg, max_next;
    dir_idx_t            dir_reg, dir_next;     // stack entry at the current depth
    logic [TAG_W-1:0]    epoch_reg, epoch_next;
    logic                clr_reg;
    logic [CELL_W-1:0]   clr_addr_reg;
    logic                clr_mark_reg;
    logic                fetch_reg;
    logic                m_valid_reg;
    result_t             m_data_reg;
    logic [TAG_W-1:0]    vis_rd_reg;            // tag of the cell ahead
    dir_idx_t            par_dir_reg;           // stack entry one below the top

    logic [TAG_W-1:0]    vis_mem [CELLS];
    dir_idx_t            stk_mem [CELLS];

    // Beat decode
    logic                      s_acc;
    logic [REPLY_W-1:0]        in_reply;
    logic signed [COORD_W-1:0] in_sx, in_sy;
    logic                      start_ok;

    assign s_tready = !clr_reg && !fetch_reg && (!m_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign in_reply = s_tdata[1:0];
    assign in_sx    = s_tdata[7:2];
    assign in_sy    = s_tdata[13:8];
    assign start_ok = (int'(in_sx) >= int'(C_MIN)) && (int'(in_sx) <= int'(C_MAX)) &&
                      (int'(in_sy) >= int'(C_MIN)) && (int'(in_sy) <= int'(C_MAX));

    coord_t      tgt_x, tgt_y;
    logic        tgt_seen;
    assign tgt_x    = step_x(cur_x_reg, dir_reg);
    assign tgt_y    = step_y(cur_y_reg, dir_reg);
    assign tgt_seen = (vis_rd_reg == epoch_reg);

    // Next state
    result_t             res;
    logic                res_valid;
    logic                vis_we;
    logic [CELL_W-1:0]   vis_waddr;
    logic [TAG_W-1:0]    vis_wdata;
    logic                stk_we;
    logic                start_clear;

    always_comb begin
        logic     adv;
        logic     prb;
        coord_t   pr_x, pr_y;
        dir_idx_t pr_d;
        logic [DEPTH_W-1:0] pr_depth;
        logic     err;

        phase_next  = phase_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        depth_next  = depth_reg;
        max_next    = max_reg;
        dir_next    = dir_reg;
        epoch_next  = epoch_reg;
        res         = '0;
        res_valid   = 1'b0;
        vis_we      = 1'b0;
        vis_waddr   = {tgt_x, tgt_y};
        vis_wdata   = epoch_reg;
        stk_we      = 1'b0;
        start_clear = 1'b0;
        adv         = 1'b0;
        prb         = 1'b0;
        pr_x        = cur_x_reg;
        pr_y        = cur_y_reg;
        pr_d        = dir_reg;
        pr_depth    = depth_reg;
        err         = 1'b0;

        if (s_acc) begin
            if (s_tuser == FUNC_START) begin
                depth_next = '0;
                max_next   = '0;
                phase_next = PH_IDLE;
                if (epoch_reg == TAG_LAST) begin
                    // tag rolls over: sweep the map, marking the start cell if it is in bounds
                    start_clear = 1'b1;
                    epoch_next  = TAG_FIRST;
                end else begin
                    epoch_next = epoch_reg + TAG_W'(1);
                end
                if (!start_ok) begin
                    res_valid    = 1'b1;
                    res.kind     = KIND_BOUND;
                    res.move_dir = MOVE_NONE;
                    res.pos_x    = in_sx;
                    res.pos_y    = in_sy;
                end else begin
                    cur_x_next = coord_t'(in_sx);
                    cur_y_next = coord_t'(in_sy);
                    dir_next   = IDX_NORTH;
                    vis_we     = !start_clear;
                    vis_waddr  = {coord_t'(in_sx), coord_t'(in_sy)};
                    vis_wdata  = epoch_next;
                    prb        = 1'b1;
                    pr_x       = coord_t'(in_sx);
                    pr_y       = coord_t'(in_sy);
                    pr_d       = IDX_NORTH;
                    pr_depth   = '0;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_PROBE: begin
                        priority if ((in_reply == REPLY_MOVED || in_reply == REPLY_FOUND)
                                     && tgt_seen) begin
                            phase_next   = PH_UNDO;
                            res_valid    = 1'b1;
                            res.kind     = KIND_MOVE;
                            res.move_dir = dir_code(rev_dir(dir_reg));
                            res.steps    = STEPS_W'(depth_reg);
                            res.pos_x    = COORD_W'(tgt_x);
                            res.pos_y    = COORD_W'(tgt_y);
                        end else if (in_reply == REPLY_FOUND) begin
                            phase_next   = PH_IDLE;
                            res_valid    = 1'b1;
                            res.kind     = KIND_DONE;
                            res.move_dir = MOVE_NONE;
                            res.found    = 1'b1;
                            res.steps    = STEPS_W'({1'b0, depth_reg} + (DEPTH_W+1)'(1));
                            res.pos_x    = COORD_W'(tgt_x);
                            res.pos_y    = COORD_W'(tgt_y);
                        end else if (in_reply == REPLY_MOVED) begin
                            vis_we     = 1'b1;
                            stk_we     = 1'b1;
                            cur_x_next = tgt_x;
                            cur_y_next = tgt_y;
                            depth_next = depth_reg + DEPTH_W'(1);
                            if (depth_next > max_reg) begin
                                max_next = depth_next;
                            end
                            dir_next = IDX_NORTH;
                            prb      = 1'b1;
                            pr_x     = tgt_x;
                            pr_y     = tgt_y;
                            pr_d     = IDX_NORTH;
                            pr_depth = depth_next;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: adv = 1'b1;
                endcase
            end

            if (adv) begin
                priority if (dir_reg != IDX_EAST) begin
                    dir_next = dir_reg + 2'd1;
                    prb      = 1'b1;
                    pr_d     = dir_next;
                end else if (depth_reg == '0) begin
                    phase_next   = PH_IDLE;
                    res_valid    = 1'b1;
                    res.kind     = KIND_DONE;
                    res.move_dir = MOVE_NONE;
                    res.steps    = STEPS_W'(max_reg);
                    res.pos_x    = COORD_W'(cur_x_reg);
                    res.pos_y    = COORD_W'(cur_y_reg);
                end else begin
                    // back out along the direction that led here
                    cur_x_next   = step_x(cur_x_reg, rev_dir(par_dir_reg));
                    cur_y_next   = step_y(cur_y_reg, rev_dir(par_dir_reg));
                    depth_next   = depth_reg - DEPTH_W'(1);
                    dir_next     = par_dir_reg;
                    phase_next   = PH_BACK;
                    res_valid    = 1'b1;
                    res.kind     = KIND_MOVE;
                    res.move_dir = dir_code(rev_dir(par_dir_reg));
                    res.steps    = STEPS_W'(depth_reg);
                    res.pos_x    = COORD_W'(cur_x_reg);
                    res.pos_y    = COORD_W'(cur_y_reg);
                end
            end

            if (prb) begin
                err          = leaves_grid(pr_x, pr_y, pr_d);
                phase_next   = err ? PH_IDLE : PH_PROBE;
                res_valid    = 1'b1;
                res.kind     = err ? KIND_BOUND : KIND_MOVE;
                res.move_dir = dir_code(pr_d);
                res.found    = 1'b0;
                res.steps    = STEPS_W'(pr_depth);
                res.pos_x    = COORD_W'(pr_x);
                res.pos_y    = COORD_W'(pr_y);
            end
        end

        // map sweep owns the write port while it runs
        if (clr_reg) begin
            vis_we    = 1'b1;
            vis_waddr = clr_addr_reg;
            vis_wdata = (clr_mark_reg && clr_addr_reg == {cur_x_reg, cur_y_reg}) ?
                        TAG_FIRST : '0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            depth_reg    <= '0;
            max_reg      <= '0;
            dir_reg      <= IDX_NORTH;
            epoch_reg    <= TAG_FIRST;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            clr_mark_reg <= 1'b0;
            fetch_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            depth_reg <= depth_next;
            max_reg   <= max_next;
            dir_reg   <= dir_next;
            epoch_reg <= epoch_next;
            // read cycle after the last sweep write or after a beat that starts no sweep
            fetch_reg <= (clr_reg && clr_addr_reg == {CELL_W{1'b1}}) ||
                         (s_acc && !start_clear);
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + CELL_W'(1);
                if (clr_addr_reg == {CELL_W{1'b1}}) begin
                    clr_reg <= 1'b0;
                end
            end
            if (s_acc && start_clear) begin
                clr_reg      <= 1'b1;
                clr_addr_reg <= '0;
                clr_mark_reg <= start_ok;
            end
            if (s_acc && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && res_valid) begin
            m_data_reg <= res;
        end
    end

    // Visited map: run tag per cell
    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (fetch_reg) begin
            vis_rd_reg <= vis_mem[{tgt_x, tgt_y}];
        end
    end

    // Direction stack: entries below the top; the top lives in dir_reg
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[depth_reg] <= dir_reg;
        end
        if (fetch_reg) begin
            par_dir_reg <= stk_mem[depth_reg - DEPTH_W'(1)];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.kind;
    assign m_tdata  = {4'b0, m_data_reg.pos_y, m_data_reg.pos_x, m_data_reg.steps,
                       m_data_reg.found, m_data_reg.move_dir};

endmodule
